FILE: sv/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define MGRQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition in one cycle is followed by a consequence in the next.
`define MGRQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    `MGRQ_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

FILE: sv/mgrq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgrq_pkg
// Shared types, codes and the per-application memory requirement table.
// ----------------------------------------------------------------------------
package mgrq_pkg;

    localparam int APP_W = 4;
    localparam int MEM_W = 20;
    localparam int STATUS_W = 3;
    localparam int FUNC_W = 2;

    // Reset value of the memory budget, in MB
    localparam logic [MEM_W-1:0] TOTAL_RESET = 20'd4096;

    typedef enum logic [FUNC_W-1:0] {
        FN_SUBMIT   = 2'd0,
        FN_DISPATCH = 2'd1,
        FN_RELEASE  = 2'd2,
        FN_IDLE     = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_QUEUED    = 3'd0,
        ST_DROPPED   = 3'd1,
        ST_LAUNCHED  = 3'd2,
        ST_REQUEUED  = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_RELEASED  = 3'd5,
        ST_UNDERFLOW = 3'd6
    } status_t;

    // Queue operation issued by the scheduler to the ring
    typedef struct packed {
        logic             push;
        logic             pop;
        logic [APP_W-1:0] data;
    } ring_op_t;

    // Fixed memory requirement in MB; ids without an entry need nothing
    function automatic logic [MEM_W-1:0] need_mb(input logic [APP_W-1:0] id);
        logic [MEM_W-1:0] mb;
        unique case (id)
            4'd0:    mb = 20'd20;
            4'd1:    mb = 20'd15;
            4'd2:    mb = 20'd100;
            4'd3:    mb = 20'd50;
            4'd4:    mb = 20'd200;
            4'd5:    mb = 20'd100;
            4'd6:    mb = 20'd10;
            4'd7:    mb = 20'd50;
            4'd8:    mb = 20'd60;
            4'd9:    mb = 20'd300;
            default: mb = '0;
        endcase
        return mb;
    endfunction

endpackage

FILE: sv/mgrq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgrq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mgrq_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/mgrq_ring.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// mgrq_ring
// Ring queue of application ids: head pointer, fill count and the id store.
// The head entry is prefetched through the RAM read port, with a one-entry
// bypass for a write that lands on the next head slot.
// ----------------------------------------------------------------------------
module mgrq_ring
    import mgrq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ring_op_t                       op,
    output logic [APP_W-1:0]               head_id,
    output logic [$clog2(DEPTH+1)-1:0]     count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W:0]   DEPTH_X   = (PTR_W + 1)'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [PTR_W:0]   tail_sum;
    logic [PTR_W-1:0] tail_slot;
    logic             bypass_valid_reg;
    logic             bypass_valid_next;
    logic [APP_W-1:0] bypass_data_reg;
    logic [APP_W-1:0] ram_rdata;

    // Tail slot is head plus count, wrapped once
    always_comb
    begin
        tail_sum = (PTR_W + 1)'(head_reg) + (PTR_W + 1)'(count_reg);
        if (tail_sum >= DEPTH_X)
        begin
            tail_slot = PTR_W'(tail_sum - DEPTH_X);
        end
        else
        begin
            tail_slot = PTR_W'(tail_sum);
        end
    end

    // Advance head on pop, adjust count by push and pop
    always_comb
    begin
        if (op.pop)
        begin
            head_next = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
        end
        else
        begin
            head_next = head_reg;
        end
        count_next = count_reg + CNT_W'(op.push) - CNT_W'(op.pop);
        bypass_valid_next = op.push && (tail_slot == head_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg         <= '0;
            count_reg        <= '0;
            bypass_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg         <= head_next;
            count_reg        <= count_next;
            bypass_valid_reg <= bypass_valid_next;
        end
    end

    // Hold the id just written for a read of the same slot
    always_ff @(posedge clk)
    begin
        bypass_data_reg <= op.data;
    end

    mgrq_ram #(
        .WIDTH (APP_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (op.push),
        .waddr (tail_slot),
        .wdata (op.data),
        .raddr (head_next),
        .rdata (ram_rdata)
    );

    assign head_id = bypass_valid_reg ? bypass_data_reg : ram_rdata;
    assign count   = count_reg;

    `MGRQ_ASSERT(a_pop_not_empty, clk, rst_n, op.pop |-> (count_reg != '0), "pop from empty ring")
    `MGRQ_ASSERT(a_push_not_full, clk, rst_n, (op.push && !op.pop) |-> (count_reg != CNT_W'(DEPTH)), "push into full ring")

endmodule

FILE: sv/memory_gated_ready_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// memory_gated_ready_queue
// Ready queue of application ids gated by a memory credit: submit, dispatch
// with launch or requeue, and completion that returns the reservation.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  -------   ------------------   -----------------------------------------
//  request   start / busy         func, app_id
//  result    done (strobe)        status, app_out, free_memory, queue_count
//  config    cfg_we               cfg_data (memory budget in MB)
//
//  One request is taken every cycle; busy stays low.
//  A request is captured in the request register, resolved in one pass,
//  and its result is registered and strobes on done.
//  The head id comes from the store's registered read port, prefetched at
//  the next head address, so back-to-back dispatches run at full rate.
//  Reset empties the queue, clears reserved memory and sets the budget to
//  4096 MB; the id store needs no clearing pass.
//  The receiver cannot stall; each result is shown for one cycle.
// ----------------------------------------------------------------------------
module memory_gated_ready_queue
    import mgrq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [FUNC_W-1:0]                func,
    input  logic [APP_W-1:0]                 app_id,
    input  logic                             cfg_we,
    input  logic [MEM_W-1:0]                 cfg_data,
    output logic                             done,
    output logic [STATUS_W-1:0]              status,
    output logic [APP_W-1:0]                 app_out,
    output logic [MEM_W-1:0]                 free_memory,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] queue_count
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

    // Request register
    logic             req_valid_reg;
    func_t            func_reg;
    logic [APP_W-1:0] app_reg;

    // Credit state
    logic [MEM_W-1:0] total_reg;
    logic [MEM_W-1:0] used_reg;
    logic [MEM_W-1:0] used_next;

    // Result register
    logic             done_reg;
    status_t          status_reg;
    status_t          status_next;
    logic [APP_W-1:0] app_out_reg;
    logic [APP_W-1:0] app_out_next;
    logic [MEM_W-1:0] free_reg;
    logic [MEM_W-1:0] free_next;
    logic [CNT_W-1:0] qcount_reg;
    logic [CNT_W-1:0] qcount_next;

    // Working signals
    ring_op_t         ring_op;
    logic [APP_W-1:0] head_id;
    logic [CNT_W-1:0] ring_count;
    logic [MEM_W-1:0] free_cur;
    logic [MEM_W-1:0] head_need;
    logic [MEM_W-1:0] app_need;

    assign busy = 1'b0;

    // Capture the request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            func_reg <= func_t'(func);
            app_reg  <= app_id;
        end
    end

    // Resolve the request against queue and credit
    always_comb
    begin
        free_cur     = (total_reg > used_reg) ? total_reg - used_reg : '0;
        head_need    = need_mb(head_id);
        app_need     = need_mb(app_reg);
        used_next    = used_reg;
        status_next  = ST_EMPTY;
        app_out_next = '0;
        ring_op      = '{push: 1'b0, pop: 1'b0, data: app_reg};

        if (req_valid_reg)
        begin
            unique case (func_reg)
                FN_SUBMIT:
                begin
                    app_out_next = app_reg;
                    if (ring_count == FULL_COUNT)
                    begin
                        status_next = ST_DROPPED;
                    end
                    else
                    begin
                        ring_op.push = 1'b1;
                        status_next  = ST_QUEUED;
                    end
                end
                FN_DISPATCH:
                begin
                    if (ring_count != '0)
                    begin
                        ring_op.pop  = 1'b1;
                        app_out_next = head_id;
                        if (free_cur >= head_need)
                        begin
                            used_next   = used_reg + head_need;
                            status_next = ST_LAUNCHED;
                        end
                        else
                        begin
                            ring_op.push = 1'b1;
                            ring_op.data = head_id;
                            status_next  = ST_REQUEUED;
                        end
                    end
                end
                FN_RELEASE:
                begin
                    app_out_next = app_reg;
                    if (app_need > used_reg)
                    begin
                        used_next   = '0;
                        status_next = ST_UNDERFLOW;
                    end
                    else
                    begin
                        used_next   = used_reg - app_need;
                        status_next = ST_RELEASED;
                    end
                end
                default:
                begin
                    status_next = ST_EMPTY;
                end
            endcase
        end

        free_next   = (total_reg > used_next) ? total_reg - used_next : '0;
        qcount_next = ring_count + CNT_W'(ring_op.push) - CNT_W'(ring_op.pop);
    end

    mgrq_ring #(
        .DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (ring_op),
        .head_id (head_id),
        .count   (ring_count)
    );

    // Hold credit state and the budget register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= TOTAL_RESET;
            used_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                total_reg <= cfg_data;
            end
            used_reg <= used_next;
            done_reg <= req_valid_reg;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (req_valid_reg)
        begin
            status_reg  <= status_next;
            app_out_reg <= app_out_next;
            free_reg    <= free_next;
            qcount_reg  <= qcount_next;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign app_out     = app_out_reg;
    assign free_memory = free_reg;
    assign queue_count = qcount_reg;

    `MGRQ_ASSERT(a_free_within_budget, clk, rst_n, done_reg |-> (free_reg <= $past(total_reg)), "free memory above budget")
    `MGRQ_ASSERT_NEXT(a_dispatch_resolves, clk, rst_n, req_valid_reg && (func_reg == FN_DISPATCH) && (ring_count != '0), done_reg && ((status_reg == ST_LAUNCHED) || (status_reg == ST_REQUEUED)), "dispatch on nonempty queue not resolved")

endmodule

FILE: verif/mgrq_schedule_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgrq_schedule_checker
// Watches the request, config and result channels of the memory gated ready
// queue. It keeps its own ring, reservation and budget, works out the status
// of every accepted request, and compares each strobed result field by field
// against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module mgrq_schedule_checker
    import mgrq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int CNT_W = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic [FUNC_W-1:0]   func,
    input  logic [APP_W-1:0]    app_id,
    input  logic                cfg_we,
    input  logic [MEM_W-1:0]    cfg_data,
    input  logic                done,
    input  logic [STATUS_W-1:0] status,
    input  logic [APP_W-1:0]    app_out,
    input  logic [MEM_W-1:0]    free_memory,
    input  logic [CNT_W-1:0]    queue_count,
    output int                  mismatches,
    output int                  results_seen,
    output int                  outstanding
);

    typedef struct packed {
        status_t          st;
        logic [APP_W-1:0] app;
        logic [MEM_W-1:0] free;
        logic [CNT_W-1:0] cnt;
    } sched_result_t;

    // Shadow of the scheduler state
    logic [APP_W-1:0] ready_ring [DEPTH];
    int unsigned      ring_head;
    int unsigned      ring_count;
    logic [MEM_W-1:0] reserved_mb;
    logic [MEM_W-1:0] budget_mb;
    logic [MEM_W-1:0] app_need_mb [16];

    sched_result_t    pending_results [$];
    int               fail_count;
    int               strobe_count;

    // Fixed requirement per application id; ids ten and up need nothing
    initial begin
        app_need_mb = '{20'd20, 20'd15, 20'd100, 20'd50, 20'd200, 20'd100, 20'd10,
                        20'd50, 20'd60, 20'd300, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0,
                        20'd0};
    end

    function automatic logic [MEM_W-1:0] unreserved_mb();
        return (budget_mb > reserved_mb) ? budget_mb - reserved_mb : '0;
    endfunction

    // Apply one request to the shadow state and return the result it yields
    function automatic sched_result_t predict_schedule_step(input func_t op,
                                                            input logic [APP_W-1:0] id);
        sched_result_t    r;
        logic [APP_W-1:0] head_id;
        logic [MEM_W-1:0] req_mb;
        r.st  = ST_EMPTY;
        r.app = '0;
        case (op)
            FN_SUBMIT:
            begin
                r.app = id;
                if (ring_count >= DEPTH) begin
                    r.st = ST_DROPPED;
                end else begin
                    ready_ring[(ring_head + ring_count) % DEPTH] = id;
                    ring_count++;
                    r.st = ST_QUEUED;
                end
            end
            FN_DISPATCH:
            begin
                if (ring_count != 0) begin
                    head_id    = ready_ring[ring_head];
                    ring_head  = (ring_head + 1) % DEPTH;
                    ring_count--;
                    req_mb     = app_need_mb[head_id];
                    r.app      = head_id;
                    if (unreserved_mb() >= req_mb) begin
                        reserved_mb = reserved_mb + req_mb;
                        r.st        = ST_LAUNCHED;
                    end else begin
                        // Short on memory: rotate the head to the tail
                        ready_ring[(ring_head + ring_count) % DEPTH] = head_id;
                        ring_count++;
                        r.st = ST_REQUEUED;
                    end
                end
            end
            FN_RELEASE:
            begin
                req_mb = app_need_mb[id];
                r.app  = id;
                if (req_mb > reserved_mb) begin
                    reserved_mb = '0;
                    r.st        = ST_UNDERFLOW;
                end else begin
                    reserved_mb = reserved_mb - req_mb;
                    r.st        = ST_RELEASED;
                end
            end
            default:
            begin
            end
        endcase
        r.free = unreserved_mb();
        r.cnt  = CNT_W'(ring_count);
        return r;
    endfunction

    // Track config, requests and results on every edge
    always @(posedge clk or negedge rst_n) begin : track
        sched_result_t want;
        if (!rst_n) begin
            ring_head    = 0;
            ring_count   = 0;
            reserved_mb  = '0;
            budget_mb    = TOTAL_RESET;
            pending_results.delete();
            fail_count   = 0;
            strobe_count = 0;
            mismatches   <= 0;
            results_seen <= 0;
            outstanding  <= 0;
        end else begin
            if (cfg_we)
                budget_mb = cfg_data;

            // Compare a strobed result with the oldest prediction
            if (done) begin
                strobe_count++;
                if (pending_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result with none outstanding: status %0d app %0d free %0d count %0d",
                                 $time, status, app_out, free_memory, queue_count);
                end else begin
                    want = pending_results.pop_front();
                    if (status !== want.st || app_out !== want.app ||
                        free_memory !== want.free || queue_count !== want.cnt) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch exp status %0d app %0d free %0d count %0d, got status %0d app %0d free %0d count %0d",
                                     $time, want.st, want.app, want.free, want.cnt,
                                     status, app_out, free_memory, queue_count);
                    end
                end
            end

            // Predict every accepted request
            if (start && !busy)
                pending_results.push_back(predict_schedule_step(func_t'(func), app_id));

            mismatches   <= fail_count;
            results_seen <= strobe_count;
            outstanding  <= pending_results.size();
        end
    end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the memory gated ready queue with a short directed run (empty
// dispatch, unused function code, release underflow, zero-need ids, queue
// fill and overflow) and then random submit, dispatch and completion mixes
// under several memory budgets, with random request gaps. The checker
// module predicts and compares; this top only makes stimulus and judges.
// ----------------------------------------------------------------------------
module testbench;
    import mgrq_pkg::*;

    localparam int DEPTH          = 16;
    localparam int CNT_W          = $clog2(DEPTH + 1);
    localparam int RESULT_LATENCY = 4;
    localparam int PHASE_ITEMS    = 225;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [FUNC_W-1:0]   func;
    logic [APP_W-1:0]    app_id;
    logic                cfg_we;
    logic [MEM_W-1:0]    cfg_data;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [APP_W-1:0]    app_out;
    logic [MEM_W-1:0]    free_memory;
    logic [CNT_W-1:0]    queue_count;

    int                  mismatches;
    int                  results_seen;
    int                  outstanding;
    int                  requests_sent;
    bit                  back_to_back;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    memory_gated_ready_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .app_id     (app_id),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .done       (done),
        .status     (status),
        .app_out    (app_out),
        .free_memory(free_memory),
        .queue_count(queue_count)
    );

    mgrq_schedule_checker #(
        .DEPTH(DEPTH),
        .CNT_W(CNT_W)
    ) u_sched_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .app_id      (app_id),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .done        (done),
        .status      (status),
        .app_out     (app_out),
        .free_memory (free_memory),
        .queue_count (queue_count),
        .mismatches  (mismatches),
        .results_seen(results_seen),
        .outstanding (outstanding)
    );

    // Hold a request until accepted, then idle for the given cycles
    task automatic issue_request(input func_t op, input logic [APP_W-1:0] id,
                                 input int idle);
        start  <= 1'b1;
        func   <= op;
        app_id <= id;
        do @(posedge clk); while (busy);
        requests_sent++;
        if (idle > 0) begin
            start <= 1'b0;
            repeat (idle) @(posedge clk);
        end
    endtask

    // Wait for every outstanding result, then let the pipeline settle
    task automatic drain_results();
        while (results_seen != requests_sent) @(posedge clk);
        repeat (RESULT_LATENCY) @(posedge clk);
    endtask

    task automatic write_budget(input logic [MEM_W-1:0] mb);
        cfg_we   <= 1'b1;
        cfg_data <= mb;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Empty dispatch, unused code, underflow, zero-need launch, fill and overflow
    task automatic directed_requests();
        issue_request(FN_DISPATCH, 4'd0, $urandom_range(0, 2));
        issue_request(FN_IDLE, 4'd15, $urandom_range(0, 2));
        issue_request(FN_RELEASE, 4'd9, $urandom_range(0, 2));
        issue_request(FN_RELEASE, 4'd15, $urandom_range(0, 2));
        issue_request(FN_SUBMIT, 4'd15, $urandom_range(0, 2));
        issue_request(FN_DISPATCH, 4'd4, $urandom_range(0, 2));
        for (int i = 0; i < 16; i++)
            issue_request(FN_SUBMIT, APP_W'(i), $urandom_range(0, 2));
        issue_request(FN_SUBMIT, 4'd9, $urandom_range(0, 2));
        issue_request(FN_DISPATCH, 4'd11, 1);
    endtask

    // Random mix; the submit share varies per phase so the queue runs both
    // near empty and near full
    task automatic random_requests(input int n);
        int               submit_pct;
        int               pick;
        int               gap;
        func_t            op;
        logic [APP_W-1:0] id;
        submit_pct = $urandom_range(25, 60);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 23) == 0)
                back_to_back = !back_to_back;
            gap = back_to_back ? 0 : $urandom_range(0, 6);
            if (i == n - 1 && gap == 0)
                gap = 1;
            pick = $urandom_range(0, 99);
            if (pick < submit_pct)
                op = FN_SUBMIT;
            else if (pick < submit_pct + 35)
                op = FN_DISPATCH;
            else if (pick < 97)
                op = FN_RELEASE;
            else
                op = FN_IDLE;
            if ($urandom_range(0, 4) == 0)
                id = APP_W'($urandom_range(10, 15));
            else
                id = APP_W'($urandom_range(0, 9));
            issue_request(op, id, gap);
        end
    endtask

    // Stimulus and verdict
    initial begin
        logic [MEM_W-1:0] budgets [5];
        requests_sent = 0;
        back_to_back  = 1'b0;
        rst_n    <= 1'b0;
        start    <= 1'b0;
        func     <= FN_SUBMIT;
        app_id   <= '0;
        cfg_we   <= 1'b0;
        cfg_data <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_requests();
        random_requests(PHASE_ITEMS);
        drain_results();

        // No budget, full budget, a budget below what is reserved, random, then 350 MB
        budgets[0] = '0;
        budgets[1] = '1;
        budgets[2] = 20'd150;
        budgets[3] = MEM_W'($urandom_range(0, 20'hFFFFF));
        budgets[4] = 20'd350;
        foreach (budgets[p]) begin
            write_budget(budgets[p]);
            random_requests(PHASE_ITEMS);
            drain_results();
        end

        if (mismatches == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog
    initial begin
        #400000;
        $display("status: fail");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/mgrq_pkg.sv
sv/mgrq_ram.sv
sv/mgrq_ring.sv
sv/memory_gated_ready_queue.sv
verif/mgrq_schedule_checker.sv
verif/testbench.sv
